### sv/blsm_pkg.sv
// ----------------------------------------------------------------------------
// blsm_pkg
// Shared constants, codes and types of the Bulgarian light stemmer.
// ----------------------------------------------------------------------------
`default_nettype none
package blsm_pkg;

    localparam int MAX_WORD = 32;
    localparam int CNT_W    = $clog2(MAX_WORD + 1);

    localparam logic [15:0] CH_A    = 16'h0430;
    localparam logic [15:0] CH_V    = 16'h0432;
    localparam logic [15:0] CH_G    = 16'h0433;
    localparam logic [15:0] CH_E    = 16'h0435;
    localparam logic [15:0] CH_Z    = 16'h0437;
    localparam logic [15:0] CH_I    = 16'h0438;
    localparam logic [15:0] CH_J    = 16'h0439;
    localparam logic [15:0] CH_K    = 16'h043A;
    localparam logic [15:0] CH_N    = 16'h043D;
    localparam logic [15:0] CH_O    = 16'h043E;
    localparam logic [15:0] CH_S    = 16'h0441;
    localparam logic [15:0] CH_T    = 16'h0442;
    localparam logic [15:0] CH_H    = 16'h0445;
    localparam logic [15:0] CH_C    = 16'h0446;
    localparam logic [15:0] CH_SHT  = 16'h0449;
    localparam logic [15:0] CH_HARD = 16'h044A;
    localparam logic [15:0] CH_YA   = 16'h044F;

    // sequencer states, also the rule step selector
    localparam logic [3:0] ST_LOAD  = 4'd0;
    localparam logic [3:0] ST_ISHA  = 4'd1;
    localparam logic [3:0] ST_ART   = 4'd2;
    localparam logic [3:0] ST_PLU   = 4'd3;
    localparam logic [3:0] ST_VA    = 4'd4;
    localparam logic [3:0] ST_VB    = 4'd5;
    localparam logic [3:0] ST_EN    = 4'd6;
    localparam logic [3:0] ST_HARD  = 4'd7;
    localparam logic [3:0] ST_ALIGN = 4'd8;
    localparam logic [3:0] ST_EMIT  = 4'd9;

    // cell move codes
    localparam logic [1:0] OP_HOLD = 2'd0;
    localparam logic [1:0] OP_UP   = 2'd1;
    localparam logic [1:0] OP_DOWN = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  k;
        logic        wr1;
        logic        wr2;
        logic [15:0] val;
    } ctl_t;

endpackage
`default_nettype wire

### sv/blsm_cell.sv
// ----------------------------------------------------------------------------
// blsm_cell
// One character slot of the word row: hold, shift up, drop down, rewrite.
// ----------------------------------------------------------------------------
`default_nettype none
module blsm_cell
    import blsm_pkg::*;
(
    input  wire logic        aclk,
    input  wire ctl_t        ctl,
    input  wire logic        wr_hit,
    input  wire logic [15:0] up_in,
    input  wire logic [15:0] dn1_in,
    input  wire logic [15:0] dn2_in,
    input  wire logic [15:0] dn3_in,
    output logic      [15:0] q,
    output logic      [15:0] w
);
    logic [15:0] unit_reg;
    logic [15:0] unit_next;

    // rewritten value as seen by the cells below
    assign w = wr_hit ? ctl.val : unit_reg;
    assign q = unit_reg;

    always_comb begin
        case (ctl.op)
            OP_UP:   unit_next = up_in;
            OP_DOWN: begin
                case (ctl.k)
                    2'd1:    unit_next = dn1_in;
                    2'd2:    unit_next = dn2_in;
                    2'd3:    unit_next = dn3_in;
                    default: unit_next = w;
                endcase
            end
            default: unit_next = w;
        endcase
    end

    always_ff @(posedge aclk) begin
        unit_reg <= unit_next;
    end
endmodule
`default_nettype wire

### sv/blsm_rules.sv
// ----------------------------------------------------------------------------
// blsm_rules
// Suffix rule decode for one stemming step, looking at the last four slots.
// ----------------------------------------------------------------------------
`default_nettype none
module blsm_rules
    import blsm_pkg::*;
(
    input  wire logic [3:0]       step,
    input  wire logic [CNT_W-1:0] n,
    input  wire logic             vowel_ok,
    input  wire logic [15:0]      t0,
    input  wire logic [15:0]      t1,
    input  wire logic [15:0]      t2,
    input  wire logic [15:0]      t3,
    output ctl_t                  ctl,
    output logic                  fin
);
    logic gt3, gt4, gt5, gt6;

    assign gt3 = n > CNT_W'(3);
    assign gt4 = n > CNT_W'(4);
    assign gt5 = n > CNT_W'(5);
    assign gt6 = n > CNT_W'(6);

    always_comb begin
        ctl     = '0;
        ctl.op  = OP_HOLD;
        fin     = 1'b0;
        case (step)
            ST_ISHA: begin
                if (gt5 && t2 == CH_I && t1 == CH_SHT && t0 == CH_A) begin
                    ctl.k = 2'd3;
                    fin   = 1'b1;
                end
            end
            ST_ART: begin
                if (gt6 && t2 == CH_I && t1 == CH_YA && t0 == CH_T) begin
                    ctl.k = 2'd3;
                end else if (gt5 && ((t1 == CH_HARD && t0 == CH_T) ||
                                     (t1 == CH_T && t0 == CH_O) ||
                                     (t1 == CH_T && t0 == CH_E) ||
                                     (t1 == CH_T && t0 == CH_A) ||
                                     (t1 == CH_I && t0 == CH_YA))) begin
                    ctl.k = 2'd2;
                end else if (gt4 && t1 == CH_YA && t0 == CH_T) begin
                    ctl.k = 2'd2;
                end
            end
            ST_PLU: begin
                if (gt6 && t3 == CH_O && t2 == CH_V && t1 == CH_C && t0 == CH_I) begin
                    ctl.k = 2'd3;
                end else if (gt6 && t2 == CH_O && t1 == CH_V && t0 == CH_E) begin
                    ctl.k = 2'd3;
                end else if (gt6 && t2 == CH_E && t1 == CH_V && t0 == CH_E) begin
                    ctl.wr2 = 1'b1;
                    ctl.val = CH_J;
                    ctl.k   = 2'd2;
                end else if (gt5 && t2 == CH_I && t1 == CH_SHT && t0 == CH_A) begin
                    ctl.k = 2'd3;
                end else if (gt5 && t1 == CH_T && t0 == CH_A) begin
                    ctl.k = 2'd2;
                end else if (gt5 && t1 == CH_C && t0 == CH_I) begin
                    ctl.wr1 = 1'b1;
                    ctl.val = CH_K;
                    ctl.k   = 2'd1;
                end else if (gt5 && t1 == CH_Z && t0 == CH_I) begin
                    ctl.wr1 = 1'b1;
                    ctl.val = CH_G;
                    ctl.k   = 2'd1;
                end else if (gt5 && t2 == CH_E && t0 == CH_I) begin
                    ctl.wr2 = 1'b1;
                    ctl.val = CH_YA;
                    ctl.k   = 2'd1;
                end else if (gt4 && t1 == CH_S && t0 == CH_I) begin
                    ctl.wr1 = 1'b1;
                    ctl.val = CH_H;
                    ctl.k   = 2'd1;
                end else if (gt4 && t0 == CH_I) begin
                    ctl.k = 2'd1;
                end
            end
            ST_VA: begin
                if (gt3 && t0 == CH_YA) begin
                    ctl.k = 2'd1;
                end
            end
            ST_VB: begin
                if (vowel_ok && (t0 == CH_A || t0 == CH_O || t0 == CH_E)) begin
                    ctl.k = 2'd1;
                end
            end
            ST_EN: begin
                if (gt4 && t1 == CH_E && t0 == CH_N) begin
                    ctl.wr1 = 1'b1;
                    ctl.val = CH_N;
                    ctl.k   = 2'd1;
                end
            end
            ST_HARD: begin
                if (gt5 && t1 == CH_HARD) begin
                    ctl.wr1 = 1'b1;
                    ctl.val = t0;
                    ctl.k   = 2'd1;
                end
            end
            default: begin
                ctl.k = 2'd0;
            end
        endcase
        if (ctl.k != 2'd0) begin
            ctl.op = OP_DOWN;
        end
    end
endmodule
`default_nettype wire

### sv/bulgarian_light_stemmer.sv
// ----------------------------------------------------------------------------
// bulgarian_light_stemmer
// Stores a word in a row of character cells, strips Bulgarian suffixes at
// the tail of the row, then shifts the stem out one character at a time.
// ----------------------------------------------------------------------------
//  channel | dir | tdata              | tlast        | tuser
//  s_      | in  | code_unit[15:0]    | last_of_word | -
//  m_      | out | stem_unit[15:0]    | last_of_stem | too_long[0]
//
//  load: one character per cycle, shifted into cell 0 (the word tail)
//  stemming: up to seven steps, one rule group each, on the four tail cells;
//  a trailing isha ends it after the first step, short or too long words skip it
//  align: shifting the stem up to the top cell
//  emit: one character per cycle from the top cell, stalls with m_tready
//  s_tready is high only while loading; aresetn clears all control state
// ----------------------------------------------------------------------------
`default_nettype none
module bulgarian_light_stemmer
    import blsm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // code_unit[15:0]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // stem_unit[15:0]
    output logic             m_tlast,
    output logic      [0:0]  m_tuser    // too_long[0]
);
    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] aln_reg, aln_next;
    logic             ovf_reg, ovf_next;
    logic             vok_reg, vok_next;
    logic             mv_reg, mv_next;
    logic [15:0]      md_reg, md_next;
    logic             ml_reg, ml_next;
    logic             mu_reg, mu_next;

    ctl_t             ctl, rule_ctl;
    logic             rule_fin;
    logic [15:0]      q_arr [MAX_WORD];
    logic [15:0]      w_arr [MAX_WORD];
    logic [CNT_W-1:0] n_inc;
    logic             out_free;

    blsm_rules u_rules (
        .step     (state_reg),
        .n        (n_reg),
        .vowel_ok (vok_reg),
        .t0       (q_arr[0]),
        .t1       (q_arr[1]),
        .t2       (q_arr[2]),
        .t3       (q_arr[3]),
        .ctl      (rule_ctl),
        .fin      (rule_fin)
    );

    genvar gi;
    generate
        for (gi = 0; gi < MAX_WORD; gi++) begin : g_cell
            logic [15:0] up_w, d1_w, d2_w, d3_w;
            logic        hit_w;
            if (gi == 0) begin : g_up0
                assign up_w = s_tdata;
            end else begin : g_upn
                assign up_w = q_arr[gi-1];
            end
            if (gi + 1 < MAX_WORD) begin : g_d1
                assign d1_w = w_arr[gi+1];
            end else begin : g_d1z
                assign d1_w = '0;
            end
            if (gi + 2 < MAX_WORD) begin : g_d2
                assign d2_w = w_arr[gi+2];
            end else begin : g_d2z
                assign d2_w = '0;
            end
            if (gi + 3 < MAX_WORD) begin : g_d3
                assign d3_w = w_arr[gi+3];
            end else begin : g_d3z
                assign d3_w = '0;
            end
            assign hit_w = (gi == 1 && ctl.wr1) || (gi == 2 && ctl.wr2);
            blsm_cell u_cell (
                .aclk   (aclk),
                .ctl    (ctl),
                .wr_hit (hit_w),
                .up_in  (up_w),
                .dn1_in (d1_w),
                .dn2_in (d2_w),
                .dn3_in (d3_w),
                .q      (q_arr[gi]),
                .w      (w_arr[gi])
            );
        end
    endgenerate

    assign s_tready = (state_reg == ST_LOAD);
    assign out_free = !mv_reg || m_tready;
    assign n_inc    = (n_reg < CNT_W'(MAX_WORD)) ? n_reg + CNT_W'(1) : n_reg;

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        aln_next   = aln_reg;
        ovf_next   = ovf_reg;
        vok_next   = vok_reg;
        mv_next    = mv_reg && !m_tready;
        md_next    = md_reg;
        ml_next    = ml_reg;
        mu_next    = mu_reg;
        ctl        = '0;
        ctl.op     = OP_HOLD;
        case (state_reg)
            ST_LOAD: begin
                if (s_tvalid) begin
                    if (n_reg < CNT_W'(MAX_WORD)) begin
                        ctl.op = OP_UP;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    n_next = n_inc;
                    if (s_tlast) begin
                        aln_next = n_inc;
                        if (ovf_next || n_inc < CNT_W'(4)) begin
                            state_next = ST_ALIGN;
                        end else begin
                            state_next = ST_ISHA;
                        end
                    end
                end
            end
            ST_ISHA, ST_ART, ST_PLU, ST_VA, ST_VB, ST_EN, ST_HARD: begin
                ctl    = rule_ctl;
                n_next = n_reg - CNT_W'(rule_ctl.k);
                if (state_reg == ST_VA) begin
                    vok_next = n_reg > CNT_W'(3);
                end
                aln_next = n_next;
                if (rule_fin || state_reg == ST_HARD) begin
                    state_next = ST_ALIGN;
                end else begin
                    state_next = state_reg + 4'd1;
                end
            end
            ST_ALIGN: begin
                if (aln_reg == CNT_W'(MAX_WORD)) begin
                    state_next = ST_EMIT;
                end else begin
                    ctl.op   = OP_UP;
                    aln_next = aln_reg + CNT_W'(1);
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    mv_next = 1'b1;
                    md_next = q_arr[MAX_WORD-1];
                    ml_next = (n_reg == CNT_W'(1));
                    mu_next = ovf_reg;
                    ctl.op  = OP_UP;
                    n_next  = n_reg - CNT_W'(1);
                    if (n_reg == CNT_W'(1)) begin
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            n_reg     <= '0;
            aln_reg   <= '0;
            ovf_reg   <= 1'b0;
            vok_reg   <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            n_reg     <= n_next;
            aln_reg   <= aln_next;
            ovf_reg   <= ovf_next;
            vok_reg   <= vok_next;
            mv_reg    <= mv_next;
        end
        md_reg <= md_next;
        ml_reg <= ml_next;
        mu_reg <= mu_next;
    end

    assign m_tvalid   = mv_reg;
    assign m_tdata    = md_reg;
    assign m_tlast    = ml_reg;
    assign m_tuser[0] = mu_reg;

    a_n_range: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= CNT_W'(MAX_WORD))
        else $error("fill count beyond row length");
    a_emit_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> n_reg != '0)
        else $error("emit with empty stem");
    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (n_reg == CNT_W'(MAX_WORD) || state_reg == ST_EMIT))
        else $error("overflow flag without full row");
    a_align_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ALIGN |-> aln_reg <= CNT_W'(MAX_WORD))
        else $error("align count beyond row length");
endmodule
`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Streams words into the Bulgarian light stemmer and checks every stem
// character against a software stemmer, under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
    import blsm_pkg::*;

    typedef struct packed {
        logic [15:0] unit;
        logic        last;
        logic        too_long;
    } stem_char_t;

    typedef struct {
        int          len;
        int          tn;
        logic [15:0] t0, t1, t2, t3;
        int          exp_len;    // -1: use the software stemmer
    } word_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;

    stem_char_t  stem_q[$];
    logic [15:0] sbuf[MAX_WORD];
    int          mismatches = 0;
    int          items_sent = 0;
    bit          long_hold = 1'b0;

    bulgarian_light_stemmer dut (.*);

    always #5 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic bit ends_with(int n, int k, logic [15:0] a, logic [15:0] b,
                                     logic [15:0] c, logic [15:0] d);
        logic [15:0] pat[4];
        pat[0] = a; pat[1] = b; pat[2] = c; pat[3] = d;
        if (k > n) return 1'b0;
        for (int i = 0; i < k; i++)
            if (sbuf[n - k + i] != pat[i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic int strip_article(int n);
        if (n > 6 && ends_with(n, 3, CH_I, CH_YA, CH_T, 0)) return n - 3;
        if (n > 5 && (ends_with(n, 2, CH_HARD, CH_T, 0, 0) || ends_with(n, 2, CH_T, CH_O, 0, 0)
                || ends_with(n, 2, CH_T, CH_E, 0, 0) || ends_with(n, 2, CH_T, CH_A, 0, 0)
                || ends_with(n, 2, CH_I, CH_YA, 0, 0)))
            return n - 2;
        if (n > 4 && ends_with(n, 2, CH_YA, CH_T, 0, 0)) return n - 2;
        return n;
    endfunction

    function automatic int strip_plural(int n);
        if (n > 6) begin
            if (ends_with(n, 4, CH_O, CH_V, CH_C, CH_I)) return n - 3;
            if (ends_with(n, 3, CH_O, CH_V, CH_E, 0)) return n - 3;
            if (ends_with(n, 3, CH_E, CH_V, CH_E, 0)) begin
                sbuf[n - 3] = CH_J;
                return n - 2;
            end
        end
        if (n > 5) begin
            if (ends_with(n, 3, CH_I, CH_SHT, CH_A, 0)) return n - 3;
            if (ends_with(n, 2, CH_T, CH_A, 0, 0)) return n - 2;
            if (ends_with(n, 2, CH_C, CH_I, 0, 0)) begin
                sbuf[n - 2] = CH_K;
                return n - 1;
            end
            if (ends_with(n, 2, CH_Z, CH_I, 0, 0)) begin
                sbuf[n - 2] = CH_G;
                return n - 1;
            end
            if (sbuf[n - 3] == CH_E && sbuf[n - 1] == CH_I) begin
                sbuf[n - 3] = CH_YA;
                return n - 1;
            end
        end
        if (n > 4) begin
            if (ends_with(n, 2, CH_S, CH_I, 0, 0)) begin
                sbuf[n - 2] = CH_H;
                return n - 1;
            end
            if (ends_with(n, 1, CH_I, 0, 0, 0)) return n - 1;
        end
        return n;
    endfunction

    function automatic int stem_len(int n);
        if (n < 4) return n;
        if (n > 5 && ends_with(n, 3, CH_I, CH_SHT, CH_A, 0)) return n - 3;
        n = strip_article(n);
        n = strip_plural(n);
        if (n > 3) begin
            if (ends_with(n, 1, CH_YA, 0, 0, 0)) n--;
            if (ends_with(n, 1, CH_A, 0, 0, 0) || ends_with(n, 1, CH_O, 0, 0, 0)
                    || ends_with(n, 1, CH_E, 0, 0, 0))
                n--;
        end
        if (n > 4 && ends_with(n, 2, CH_E, CH_N, 0, 0)) begin
            sbuf[n - 2] = CH_N;
            n--;
        end
        if (n > 5 && sbuf[n - 2] == CH_HARD) begin
            sbuf[n - 2] = sbuf[n - 1];
            n--;
        end
        return n;
    endfunction

    // queue the stem the block should emit for one whole word
    task automatic predict_stem(input logic [15:0] w[$], input int typed_len);
        int  n;
        bit  ovf;
        stem_char_t c;
        ovf = w.size() > MAX_WORD;
        n = ovf ? MAX_WORD : w.size();
        for (int i = 0; i < n; i++) sbuf[i] = w[i];
        if (typed_len >= 0) n = typed_len;
        else if (!ovf) n = stem_len(n);
        for (int i = 0; i < n; i++) begin
            c.unit = sbuf[i];
            c.last = (i + 1 == n);
            c.too_long = ovf;
            stem_q.push_back(c);
        end
    endtask

    task automatic send_word(input logic [15:0] w[$], input int typed_len);
        int g;
        for (int i = 0; i < w.size(); i++) begin
            g = pick_gap();
            if (g > 0) begin
                s_tvalid <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= w[i];
            s_tlast  <= (i == w.size() - 1);
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            items_sent++;
        end
        predict_stem(w, typed_len);
    endtask

    word_row_t rows[] = '{
        '{3, 3, 16'hFFFF, 16'h0000, 16'h8000, 0, 3},
        '{5, 0, 0, 0, 0, 0, -1},
        '{34, 0, 0, 0, 0, 0, 32},
        '{32, 2, CH_I, CH_YA, 0, 0, -1},
        '{33, 1, CH_A, 0, 0, 0, 32},
        '{7, 3, CH_I, CH_SHT, CH_A, 0, -1},
        '{7, 3, CH_I, CH_YA, CH_T, 0, -1},
        '{6, 2, CH_HARD, CH_T, 0, 0, -1},
        '{6, 2, CH_T, CH_O, 0, 0, -1},
        '{6, 2, CH_T, CH_E, 0, 0, -1},
        '{6, 2, CH_T, CH_A, 0, 0, -1},
        '{5, 2, CH_YA, CH_T, 0, 0, -1},
        '{7, 4, CH_O, CH_V, CH_C, CH_I, -1},
        '{7, 3, CH_O, CH_V, CH_E, 0, -1},
        '{7, 3, CH_E, CH_V, CH_E, 0, -1},
        '{6, 2, CH_C, CH_I, 0, 0, -1},
        '{6, 2, CH_Z, CH_I, 0, 0, -1},
        '{6, 3, CH_E, CH_K, CH_I, 0, -1},
        '{5, 2, CH_S, CH_I, 0, 0, -1},
        '{5, 1, CH_I, 0, 0, 0, -1},
        '{5, 1, CH_YA, 0, 0, 0, -1},
        '{6, 2, CH_E, CH_N, 0, 0, -1},
        '{7, 2, CH_HARD, CH_K, 0, 0, -1},
        '{4, 1, CH_O, 0, 0, 0, -1}
    };

    // bulk of the word from capital letters, which no rule matches
    function automatic void build_row(input word_row_t r, output logic [15:0] w[$]);
        logic [15:0] t[4];
        t[0] = r.t0; t[1] = r.t1; t[2] = r.t2; t[3] = r.t3;
        w = {};
        for (int i = 0; i < r.len - r.tn; i++) w.push_back(16'(16'h0410 + (i % 32)));
        for (int i = 0; i < r.tn; i++) w.push_back(t[i]);
    endfunction

    logic [15:0] suffixes[12][4] = '{
        '{CH_I, CH_SHT, CH_A, 0}, '{CH_I, CH_YA, CH_T, 0}, '{CH_HARD, CH_T, 0, 0},
        '{CH_YA, CH_T, 0, 0}, '{CH_O, CH_V, CH_C, CH_I}, '{CH_O, CH_V, CH_E, 0},
        '{CH_E, CH_V, CH_E, 0}, '{CH_C, CH_I, 0, 0}, '{CH_Z, CH_I, 0, 0},
        '{CH_S, CH_I, 0, 0}, '{CH_E, CH_N, 0, 0}, '{CH_HARD, CH_K, 0, 0}
    };

    function automatic void random_word(output logic [15:0] w[$]);
        int kind, len, s;
        w = {};
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            len = $urandom_range(1, 8);
            repeat (len) w.push_back(16'($urandom_range(0, 16'hFFFF)));
        end else if (kind == 1) begin
            len = $urandom_range(MAX_WORD - 2, MAX_WORD + 4);
            repeat (len) w.push_back(16'(16'h0430 + $urandom_range(0, 31)));
        end else begin
            len = $urandom_range(1, 6);
            repeat (len) w.push_back(16'(16'h0430 + $urandom_range(0, 31)));
            if (kind > 3) begin
                s = $urandom_range(0, 11);
                for (int i = 0; i < 4; i++)
                    if (suffixes[s][i] != 0) w.push_back(suffixes[s][i]);
            end
        end
    endfunction

    always @(posedge aclk) begin
        stem_char_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (stem_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected stem word %h last %b too_long %b",
                             m_tdata, m_tlast, m_tuser[0]);
            end else begin
                want = stem_q.pop_front();
                if (want.unit !== m_tdata || want.last !== m_tlast
                        || want.too_long !== m_tuser[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("stem word mismatch: exp %h/%b/%b got %h/%b/%b",
                                 want.unit, want.last, want.too_long,
                                 m_tdata, m_tlast, m_tuser[0]);
                end
            end
        end
    end

    initial begin
        int g;
        wait (aresetn);
        forever begin
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                long_hold = 1'b0;
            end else begin
                g = pick_gap();
                if (g > 0) begin
                    m_tready <= 1'b0;
                    repeat (g) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    initial begin
        #5ms;
        $display("[bulgarian_light_stemmer] ERROR");
        $finish;
    end

    initial begin
        logic [15:0] w[$];
        int start;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (rows[i]) begin
            build_row(rows[i], w);
            send_word(w, rows[i].exp_len);
        end
        start = items_sent;
        while (items_sent - start < 110) begin
            if (items_sent - start > 30 && items_sent - start < 40) long_hold = 1'b1;
            if (items_sent - start > 70 && items_sent - start < 80) begin
                // let every stem drain before going on
                s_tvalid <= 1'b0;
                wait (stem_q.size() == 0);
                @(posedge aclk);
            end
            random_word(w);
            send_word(w, -1);
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        wait (stem_q.size() == 0);
        repeat (MAX_WORD + 20) @(posedge aclk);
        if (mismatches == 0 && stem_q.size() == 0)
            $display("[bulgarian_light_stemmer] OK");
        else
            $display("[bulgarian_light_stemmer] ERROR");
        $finish;
    end
endmodule
